### design/exyzr_pkg.sv
`timescale 1ns / 1ps

package exyzr_pkg;

    // Binary angle width: one full turn spans 2^16 units.
    localparam int ANGLE_W = 16;

    // Number of configuration registers and their word indexes.
    localparam int NUM_REGS = 3;

    typedef enum logic [1:0] {
        REG_ANGLE_X = 2'd0,
        REG_ANGLE_Y = 2'd1,
        REG_ANGLE_Z = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    // Trigonometry runs in unsigned Q.32 whatever the coefficient precision.
    localparam logic [32:0] Q32_ONE  = 33'h1_0000_0000;
    localparam logic [41:0] PI_Q40   = 42'h3243F6A8886;
    localparam int          SIN_TERMS = 5;
    localparam int          COS_TERMS = 6;

    // Division by a series divisor is a multiplication by ceil(2^41 / d),
    // which gives the exact quotient for any numerator below 2^33.
    localparam int RECIP_SHIFT = 41;
    localparam logic [40:0] RCP_132 = 41'(((64'd1 << 41) + 64'd131) / 64'd132);
    localparam logic [40:0] RCP_110 = 41'(((64'd1 << 41) + 64'd109) / 64'd110);
    localparam logic [40:0] RCP_90  = 41'(((64'd1 << 41) + 64'd89) / 64'd90);
    localparam logic [40:0] RCP_72  = 41'(((64'd1 << 41) + 64'd71) / 64'd72);
    localparam logic [40:0] RCP_56  = 41'(((64'd1 << 41) + 64'd55) / 64'd56);
    localparam logic [40:0] RCP_42  = 41'(((64'd1 << 41) + 64'd41) / 64'd42);
    localparam logic [40:0] RCP_30  = 41'(((64'd1 << 41) + 64'd29) / 64'd30);
    localparam logic [40:0] RCP_20  = 41'(((64'd1 << 41) + 64'd19) / 64'd20);
    localparam logic [40:0] RCP_12  = 41'(((64'd1 << 41) + 64'd11) / 64'd12);
    localparam logic [40:0] RCP_6   = 41'(((64'd1 << 41) + 64'd5) / 64'd6);
    localparam logic [40:0] RCP_2   = 41'(((64'd1 << 41) + 64'd1) / 64'd2);

    // Series divisors for Horner evaluation of sine and cosine.
    function automatic logic [7:0] div_const(input logic is_cos, input logic [2:0] idx);
        logic [7:0] d;
        d = 8'd1;
        if (is_cos) begin
            case (idx)
                3'd0:    d = 8'd132;
                3'd1:    d = 8'd90;
                3'd2:    d = 8'd56;
                3'd3:    d = 8'd30;
                3'd4:    d = 8'd12;
                3'd5:    d = 8'd2;
                default: d = 8'd1;
            endcase
        end
        else begin
            case (idx)
                3'd0:    d = 8'd110;
                3'd1:    d = 8'd72;
                3'd2:    d = 8'd42;
                3'd3:    d = 8'd20;
                3'd4:    d = 8'd6;
                default: d = 8'd1;
            endcase
        end
        return d;
    endfunction

    // Reciprocal of the series divisor at the same position.
    function automatic logic [40:0] recip_const(input logic is_cos, input logic [2:0] idx);
        logic [40:0] m;
        m = '0;
        if (is_cos) begin
            case (idx)
                3'd0:    m = RCP_132;
                3'd1:    m = RCP_90;
                3'd2:    m = RCP_56;
                3'd3:    m = RCP_30;
                3'd4:    m = RCP_12;
                3'd5:    m = RCP_2;
                default: m = '0;
            endcase
        end
        else begin
            case (idx)
                3'd0:    m = RCP_110;
                3'd1:    m = RCP_72;
                3'd2:    m = RCP_42;
                3'd3:    m = RCP_20;
                3'd4:    m = RCP_6;
                default: m = '0;
            endcase
        end
        return m;
    endfunction

    // Q.32 product back to Q.32, rounded half up.
    function automatic logic [32:0] rnd_q32(input logic [64:0] p);
        logic [64:0] s;
        s = p + 65'h0_8000_0000;
        return s[64:32];
    endfunction

endpackage

### design/exyzr_lane.sv
`timescale 1ns / 1ps

// One row of the rotation matrix times the vector: products, then sum and rounding.
module exyzr_lane #(
    parameter int DATA_WIDTH     = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          en1,
    input  logic                          en2,
    input  logic signed [COEF_FRAC_BITS+1:0] c0,
    input  logic signed [COEF_FRAC_BITS+1:0] c1,
    input  logic signed [COEF_FRAC_BITS+1:0] c2,
    input  logic signed [DATA_WIDTH-1:0]  v0,
    input  logic signed [DATA_WIDTH-1:0]  v1,
    input  logic signed [DATA_WIDTH-1:0]  v2,
    output logic signed [DATA_WIDTH:0]    res
);

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = DATA_WIDTH + CW;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] rounded;
    logic signed [DATA_WIDTH:0] res_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p0_reg <= PW'(c0) * PW'(v0);
            p1_reg <= PW'(c1) * PW'(v1);
            p2_reg <= PW'(c2) * PW'(v2);
        end
        if (en2)
        begin
            res_reg <= (DATA_WIDTH+1)'(rounded);
        end
    end

    // Round half towards plus infinity, then drop the fraction bits.
    assign sum     = SW'(p0_reg) + SW'(p1_reg) + SW'(p2_reg);
    assign rounded = (sum + (SW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    assign res     = res_reg;

endmodule

### design/exyzr_matgen.sv
`timescale 1ns / 1ps

// Forms the rotation matrix Rz*Ry*Rx from the three angles with one shared
// Q.32 multiplier, which also divides by the series constants through their
// reciprocals in two passes, and a signed multiply-accumulate unit for the
// two matrix products.
module exyzr_matgen #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [exyzr_pkg::ANGLE_W-1:0]           angle_x,
    input  logic [exyzr_pkg::ANGLE_W-1:0]           angle_y,
    input  logic [exyzr_pkg::ANGLE_W-1:0]           angle_z,
    output logic                                    busy,
    output logic signed [COEF_FRAC_BITS+1:0]        mat [9]
);

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = 2 * CW;
    localparam int AW = PW + 2;
    localparam logic signed [CW-1:0] ONE_C = CW'(1) << COEF_FRAC_BITS;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_ANGLE  = 16'h0002,
        ST_XMUL   = 16'h0004,
        ST_SQR    = 16'h0008,
        ST_SQRR   = 16'h0010,
        ST_HMUL   = 16'h0020,
        ST_DIVSET = 16'h0040,
        ST_DIV    = 16'h0080,
        ST_DIVH   = 16'h0100,
        ST_HUPD   = 16'h0200,
        ST_SMUL   = 16'h0400,
        ST_SRES   = 16'h0800,
        ST_COEF   = 16'h1000,
        ST_MMUL   = 16'h2000,
        ST_MACC   = 16'h4000,
        ST_MSTORE = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  ang_idx_reg;
    logic [13:0] r_reg;
    logic        swap_reg;
    logic [1:0]  quad_reg;
    logic [31:0] x_reg;
    logic [31:0] x2_reg;
    logic [32:0] h_reg;
    logic [64:0] prod_reg;
    logic [64:0] dlo_reg;
    logic        is_cos_reg;
    logic [2:0]  term_reg;
    logic [32:0] num_reg;
    logic [32:0] smag_reg;

    logic signed [CW-1:0] sin_reg [3];
    logic signed [CW-1:0] cos_reg [3];
    logic signed [CW-1:0] aux_reg [9];
    logic signed [CW-1:0] mat_reg [9];

    logic [1:0]  mi_reg, mj_reg, mk_reg;
    logic        mstage_reg;
    logic signed [PW-1:0] mprod_reg;
    logic signed [AW-1:0] macc_reg;

    logic [15:0] cur_angle;
    logic [13:0] phase;
    logic [55:0] xfull;
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;
    logic [32:0] prod_rnd;
    logic [7:0]  dval;
    logic [40:0] recip;
    logic [32:0] quo;
    logic        term_last;
    logic [32:0] s0, c0;
    logic [33:0] s_sum, c_sum;
    logic signed [CW-1:0] s_mag, c_mag;
    logic signed [CW-1:0] sn_val, cs_val;
    logic signed [CW-1:0] opa, opb;
    logic [3:0]  aux_idx;
    logic [3:0]  wr_idx;
    logic signed [AW-1:0] rs_full;
    logic signed [CW-1:0] rs_val;

    always_comb
    begin
        case (ang_idx_reg)
            2'd0:    cur_angle = angle_x;
            2'd1:    cur_angle = angle_y;
            default: cur_angle = angle_z;
        endcase
    end

    assign phase = cur_angle[13:0];
    assign xfull = 56'(r_reg) * 56'(exyzr_pkg::PI_Q40) + (56'(1) << 22);

    always_comb
    begin
        mul_a = h_reg;
        mul_b = x2_reg;
        case (state_reg)
            ST_SQR:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = x_reg;
            end
            ST_SMUL:
            begin
                mul_a = h_reg;
                mul_b = x_reg;
            end
            ST_DIV:
            begin
                mul_a = num_reg;
                mul_b = recip[31:0];
            end
            ST_DIVH:
            begin
                mul_a = num_reg;
                mul_b = 32'(recip[40:32]);
            end
            default:
            begin
                mul_a = h_reg;
                mul_b = x2_reg;
            end
        endcase
    end

    assign mul_p     = 65'(mul_a) * 65'(mul_b);
    assign prod_rnd  = exyzr_pkg::rnd_q32(prod_reg);
    assign dval      = exyzr_pkg::div_const(is_cos_reg, term_reg);
    assign recip     = exyzr_pkg::recip_const(is_cos_reg, term_reg);
    // Upper partial product plus the carry-relevant half of the lower one.
    assign quo       = 33'((prod_reg + 65'(dlo_reg[64:32])) >> (exyzr_pkg::RECIP_SHIFT - 32));
    assign term_last = is_cos_reg ? (term_reg == 3'(exyzr_pkg::COS_TERMS - 1))
                                  : (term_reg == 3'(exyzr_pkg::SIN_TERMS - 1));

    // Octant symmetry, then rounding to coefficient precision and quadrant sign.
    assign s0    = swap_reg ? h_reg : smag_reg;
    assign c0    = swap_reg ? smag_reg : h_reg;
    assign s_sum = 34'(s0) + (34'd1 << (31 - COEF_FRAC_BITS));
    assign c_sum = 34'(c0) + (34'd1 << (31 - COEF_FRAC_BITS));
    assign s_mag = CW'(s_sum >> (32 - COEF_FRAC_BITS));
    assign c_mag = CW'(c_sum >> (32 - COEF_FRAC_BITS));

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                sn_val = s_mag;
                cs_val = c_mag;
            end
            2'd1:
            begin
                sn_val = c_mag;
                cs_val = -s_mag;
            end
            2'd2:
            begin
                sn_val = -s_mag;
                cs_val = -c_mag;
            end
            default:
            begin
                sn_val = -c_mag;
                cs_val = s_mag;
            end
        endcase
    end

    // Operands of the two matrix products: Ry*Rx first, then Rz*aux.
    assign aux_idx = 4'(mk_reg) * 4'd3 + 4'(mj_reg);
    assign wr_idx  = 4'(mi_reg) * 4'd3 + 4'(mj_reg);

    always_comb
    begin
        opa = '0;
        if (!mstage_reg)
        begin
            case ({mi_reg, mk_reg})
                4'b0000: opa = cos_reg[1];
                4'b0010: opa = sin_reg[1];
                4'b0101: opa = ONE_C;
                4'b1000: opa = -sin_reg[1];
                4'b1010: opa = cos_reg[1];
                default: opa = '0;
            endcase
        end
        else
        begin
            case ({mi_reg, mk_reg})
                4'b0000: opa = cos_reg[2];
                4'b0001: opa = -sin_reg[2];
                4'b0100: opa = sin_reg[2];
                4'b0101: opa = cos_reg[2];
                4'b1010: opa = ONE_C;
                default: opa = '0;
            endcase
        end
    end

    always_comb
    begin
        opb = '0;
        if (!mstage_reg)
        begin
            case ({mk_reg, mj_reg})
                4'b0000: opb = ONE_C;
                4'b0101: opb = cos_reg[0];
                4'b0110: opb = -sin_reg[0];
                4'b1001: opb = sin_reg[0];
                4'b1010: opb = cos_reg[0];
                default: opb = '0;
            endcase
        end
        else
        begin
            opb = aux_reg[aux_idx];
        end
    end

    assign rs_full = (macc_reg + (AW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    assign rs_val  = CW'(rs_full);

    always_comb
    begin
        state_next = state_reg;
        if (start)
        begin
            state_next = ST_ANGLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:   state_next = ST_IDLE;
                ST_ANGLE:  state_next = ST_XMUL;
                ST_XMUL:   state_next = ST_SQR;
                ST_SQR:    state_next = ST_SQRR;
                ST_SQRR:   state_next = ST_HMUL;
                ST_HMUL:   state_next = ST_DIVSET;
                ST_DIVSET: state_next = ST_DIV;
                ST_DIV:    state_next = ST_DIVH;
                ST_DIVH:   state_next = ST_HUPD;
                ST_HUPD:
                begin
                    if (term_last)
                    begin
                        state_next = is_cos_reg ? ST_COEF : ST_SMUL;
                    end
                    else
                    begin
                        state_next = ST_HMUL;
                    end
                end
                ST_SMUL:   state_next = ST_SRES;
                ST_SRES:   state_next = ST_HMUL;
                ST_COEF:   state_next = (ang_idx_reg == 2'd2) ? ST_MMUL : ST_ANGLE;
                ST_MMUL:   state_next = ST_MACC;
                ST_MACC:   state_next = (mk_reg == 2'd2) ? ST_MSTORE : ST_MMUL;
                ST_MSTORE:
                begin
                    if (mstage_reg && mi_reg == 2'd2 && mj_reg == 2'd2)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MMUL;
                    end
                end
                default:   state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The stored matrix resets to identity, which is what zero angles give.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 9; n++)
            begin
                mat_reg[n] <= (n == 0 || n == 4 || n == 8) ? ONE_C : '0;
            end
        end
        else if (!start && state_reg == ST_MSTORE && mstage_reg)
        begin
            mat_reg[wr_idx] <= rs_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ang_idx_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_ANGLE:
                begin
                    quad_reg <= cur_angle[15:14];
                    if (phase <= 14'd8192)
                    begin
                        r_reg    <= phase;
                        swap_reg <= 1'b0;
                    end
                    else
                    begin
                        r_reg    <= 14'(15'd16384 - 15'(phase));
                        swap_reg <= 1'b1;
                    end
                end
                ST_XMUL:
                begin
                    x_reg <= xfull[54:23];
                end
                ST_SQR, ST_HMUL, ST_SMUL, ST_DIVH:
                begin
                    prod_reg <= mul_p;
                end
                ST_SQRR:
                begin
                    x2_reg     <= prod_rnd[31:0];
                    h_reg      <= exyzr_pkg::Q32_ONE;
                    is_cos_reg <= 1'b0;
                    term_reg   <= '0;
                end
                ST_DIVSET:
                begin
                    num_reg <= prod_rnd + 33'(dval >> 1);
                end
                ST_DIV:
                begin
                    dlo_reg <= mul_p;
                end
                ST_HUPD:
                begin
                    h_reg    <= exyzr_pkg::Q32_ONE - quo;
                    term_reg <= term_reg + 3'd1;
                end
                ST_SRES:
                begin
                    smag_reg   <= prod_rnd;
                    h_reg      <= exyzr_pkg::Q32_ONE;
                    is_cos_reg <= 1'b1;
                    term_reg   <= '0;
                end
                ST_COEF:
                begin
                    sin_reg[ang_idx_reg] <= sn_val;
                    cos_reg[ang_idx_reg] <= cs_val;
                    ang_idx_reg          <= ang_idx_reg + 2'd1;
                    mi_reg     <= '0;
                    mj_reg     <= '0;
                    mk_reg     <= '0;
                    mstage_reg <= 1'b0;
                    macc_reg   <= '0;
                end
                ST_MMUL:
                begin
                    mprod_reg <= PW'(opa) * PW'(opb);
                end
                ST_MACC:
                begin
                    macc_reg <= macc_reg + AW'(mprod_reg);
                    mk_reg   <= mk_reg + 2'd1;
                end
                ST_MSTORE:
                begin
                    if (!mstage_reg)
                    begin
                        aux_reg[wr_idx] <= rs_val;
                    end
                    macc_reg <= '0;
                    mk_reg   <= '0;
                    if (mj_reg == 2'd2)
                    begin
                        mj_reg <= '0;
                        if (mi_reg == 2'd2)
                        begin
                            mi_reg     <= '0;
                            mstage_reg <= 1'b1;
                        end
                        else
                        begin
                            mi_reg <= mi_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        mj_reg <= mj_reg + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign mat  = mat_reg;

endmodule

### design/euler_xyz_vector_rotator.sv
`timescale 1ns / 1ps

// Rotates a stream of signed 3-D vectors by three Euler angles, about x,
// then y, then z (R = Rz*Ry*Rx). Angles are 16-bit binary angles in which
// 32768 means pi; they sit at byte addresses 0, 4 and 8 of the APB port and
// read back as written. Every write to an angle re-forms the stored matrix:
// sine and cosine of all three angles are evaluated in Q.32 by a shared
// multiplier, each series division being a two-pass multiplication by a
// constant reciprocal, then two 3x3 products are taken; in_stall stays high
// until the new matrix is stored. A Horner term is a multiply, a division
// set-up, two division passes and an update; a matrix product term is a
// multiply and an accumulate. After reset the matrix is the identity and no
// re-forming pass is needed. Once the matrix is ready the block takes one
// vector word per cycle while out_stall is low: three lanes, one per matrix
// row, each multiply and then sum and round, and a final output register
// merges the three lane results. An accepted word passes the product, sum
// and output registers to out_valid; the pipeline compacts bubbles, so a
// stalled output word does not block acceptance while an earlier stage is
// empty. Results are rounded to nearest with ties towards plus infinity.
module euler_xyz_vector_rotator #(
    parameter int DATA_WIDTH     = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input vector words
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [DATA_WIDTH-1:0] vec_x,
    input  logic signed [DATA_WIDTH-1:0] vec_y,
    input  logic signed [DATA_WIDTH-1:0] vec_z,
    // Rotated vector words
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DATA_WIDTH:0]  rot_x,
    output logic signed [DATA_WIDTH:0]  rot_y,
    output logic signed [DATA_WIDTH:0]  rot_z,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CW = COEF_FRAC_BITS + 2;

    // Angle registers.
    logic [exyzr_pkg::ANGLE_W-1:0] angle_x_reg, angle_y_reg, angle_z_reg;
    exyzr_pkg::reg_idx_t           reg_idx;
    logic                          wr_en;
    logic                          start;

    // Matrix former.
    logic                  busy;
    logic signed [CW-1:0]  mat [9];

    // Pipeline control: stage 1 holds products, stage 2 the rounded sums,
    // stage 3 is the merged output word.
    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;
    logic accept;

    logic signed [DATA_WIDTH:0] lane_x, lane_y, lane_z;
    logic signed [DATA_WIDTH:0] rot_x_reg, rot_y_reg, rot_z_reg;

    // ---------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high so there are no wait states.
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = exyzr_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign start   = wr_en && (reg_idx != exyzr_pkg::REG_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                exyzr_pkg::REG_ANGLE_X: angle_x_reg <= pwdata[15:0];
                exyzr_pkg::REG_ANGLE_Y: angle_y_reg <= pwdata[15:0];
                exyzr_pkg::REG_ANGLE_Z: angle_z_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            exyzr_pkg::REG_ANGLE_X: prdata = {16'd0, angle_x_reg};
            exyzr_pkg::REG_ANGLE_Y: prdata = {16'd0, angle_y_reg};
            exyzr_pkg::REG_ANGLE_Z: prdata = {16'd0, angle_z_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Matrix former: restarts from the first angle on every angle write.
    // ---------------------------------------------------------------
    exyzr_matgen #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_matgen (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .angle_x (angle_x_reg),
        .angle_y (angle_y_reg),
        .angle_z (angle_z_reg),
        .busy    (busy),
        .mat     (mat)
    );

    // ---------------------------------------------------------------
    // Stream pipeline. Each stage loads when it is empty or when the
    // stage after it moves on, so a waiting output word leaves earlier
    // stages free to fill.
    // ---------------------------------------------------------------
    assign ready3   = !v3_reg || !out_stall;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1 || busy;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= accept;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // One lane per matrix row.
    exyzr_lane #(
        .DATA_WIDTH     (DATA_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_x (
        .clk (clk),
        .en1 (ready1),
        .en2 (ready2),
        .c0  (mat[0]),
        .c1  (mat[1]),
        .c2  (mat[2]),
        .v0  (vec_x),
        .v1  (vec_y),
        .v2  (vec_z),
        .res (lane_x)
    );

    exyzr_lane #(
        .DATA_WIDTH     (DATA_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_y (
        .clk (clk),
        .en1 (ready1),
        .en2 (ready2),
        .c0  (mat[3]),
        .c1  (mat[4]),
        .c2  (mat[5]),
        .v0  (vec_x),
        .v1  (vec_y),
        .v2  (vec_z),
        .res (lane_y)
    );

    exyzr_lane #(
        .DATA_WIDTH     (DATA_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_z (
        .clk (clk),
        .en1 (ready1),
        .en2 (ready2),
        .c0  (mat[6]),
        .c1  (mat[7]),
        .c2  (mat[8]),
        .v0  (vec_x),
        .v1  (vec_y),
        .v2  (vec_z),
        .res (lane_z)
    );

    // Merge stage: the three lane results form one output word.
    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            rot_x_reg <= lane_x;
            rot_y_reg <= lane_y;
            rot_z_reg <= lane_z;
        end
    end

    assign out_valid = v3_reg;
    assign rot_x     = rot_x_reg;
    assign rot_y     = rot_y_reg;
    assign rot_z     = rot_z_reg;

endmodule

### design/exyzr_checker.sv
`timescale 1ns / 1ps

module exyzr_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic signed [DATA_WIDTH:0]  rot_x,
    input logic signed [DATA_WIDTH:0]  rot_y,
    input logic signed [DATA_WIDTH:0]  rot_z,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [3:0]                  paddr,
    input logic                        pready
);

    // A held output word keeps its value until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rot_x) && $stable(rot_y)
                                  && $stable(rot_z))
        else $error("output word changed while stalled");

    // A completed angle write starts matrix forming, which holds off input.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready
        && (exyzr_pkg::reg_idx_t'(paddr[3:2]) != exyzr_pkg::REG_NONE) |=> in_stall)
        else $error("input not held off after angle write");

    // The port has no wait states.
    assert property (@(posedge clk) pready)
        else $error("pready dropped");

    // Nothing is presented straight out of reset.
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("output valid out of reset");

endmodule

bind euler_xyz_vector_rotator exyzr_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_exyzr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pready    (pready)
);
